[hw/rtl/ssd_pkg.sv]
package ssd_pkg;

  // item kinds on the input channel
  typedef enum logic [1:0] {
    KIND_TICK = 2'd0,
    KIND_CHAR = 2'd1,
    KIND_ON   = 2'd2,
    KIND_OFF  = 2'd3
  } kind_e;

  // one text character on its way to the segment store
  typedef struct packed {
    logic       put;
    logic       start;
    logic [7:0] code;
  } ssd_wr_t;

  localparam logic [7:0]  FontFirst  = 8'h20;
  localparam logic [7:0]  FontLast   = 8'h7A;
  localparam logic [7:0]  DotCode    = 8'h2E;
  localparam logic [6:0]  SegZero    = 7'h3F;
  localparam logic [15:0] ResetDelay = 16'd500;
  localparam int          FontDepth  = 91;

  // bit 7 is the decimal point
  localparam logic [7:0] FontRom [FontDepth] = '{
    8'h00, 8'h86, 8'h22, 8'h00, 8'h00, 8'h00, 8'h00, 8'h02,
    8'h39, 8'h0F, 8'h00, 8'h00, 8'h80, 8'h40, 8'h80, 8'h52,
    8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07,
    8'h7F, 8'h6F, 8'h09, 8'h48, 8'h00, 8'h48, 8'h00, 8'h08,
    8'h00, 8'h77, 8'h7C, 8'h39, 8'h5E, 8'h79, 8'h71, 8'h3D,
    8'h76, 8'h30, 8'h1E, 8'h72, 8'h38, 8'h37, 8'h54, 8'h5C,
    8'h73, 8'h67, 8'h50, 8'h6D, 8'h78, 8'h1C, 8'h3E, 8'h6A,
    8'h49, 8'h6E, 8'h5B, 8'h39, 8'h64, 8'h0F, 8'h23, 8'h08,
    8'h00,
    8'h77, 8'h7C, 8'h39, 8'h5E, 8'h79, 8'h71, 8'h3D, 8'h76,
    8'h30, 8'h1E, 8'h72, 8'h38, 8'h37, 8'h54, 8'h5C, 8'h73,
    8'h67, 8'h50, 8'h6D, 8'h78, 8'h1C, 8'h3E, 8'h6A, 8'h49,
    8'h6E, 8'h5B
  };

  // codes outside the font come out blank
  function automatic logic [7:0] ssd_encode(input logic [7:0] code);
    logic [7:0] idx;
    idx = code - FontFirst;
    if (code < FontFirst || code > FontLast) begin
      return 8'h00;
    end
    return FontRom[idx[6:0]];
  endfunction

endpackage

[hw/rtl/ssd_text_store.sv]
module ssd_text_store #(
  parameter int DIGITS = 12,
  parameter int CNT_W  = $clog2(DIGITS + 1),
  parameter int IDX_W  = (DIGITS > 1) ? $clog2(DIGITS) : 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ssd_pkg::ssd_wr_t wr_i,
  input  logic [IDX_W-1:0] rd_idx_i,
  output logic [7:0]       rd_seg_o,
  output logic [CNT_W-1:0] text_len_o
);
  import ssd_pkg::*;

  localparam logic [IDX_W:0] Depth = (IDX_W + 1)'(DIGITS);

  // segments and decimal points kept apart so a dot is a plain bit set
  logic [6:0]       seg_q [DIGITS];
  logic             dp_q  [DIGITS];
  // write pointer and text length always move together, one register
  logic [CNT_W-1:0] wp_q, wp_d;
  logic [CNT_W-1:0] wp_eff;
  logic [7:0]       glyph;
  logic             room;
  logic             is_dot;
  logic             wr_seg;
  logic             wr_dp;
  logic [CNT_W-1:0] dp_idx;

  always_comb begin
    wp_eff = wr_i.start ? '0 : wp_q;
    glyph  = ssd_encode(wr_i.code);
    room   = wp_eff < CNT_W'(DIGITS);
    is_dot = wr_i.code == DotCode;
    wr_seg = wr_i.put && room && !is_dot;
    wr_dp  = wr_i.put && room && is_dot && (wp_eff != '0);
    dp_idx = wp_eff - CNT_W'(1);
    wp_d   = wr_seg ? wp_eff + CNT_W'(1) : (wr_i.put ? wp_eff : wp_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
      for (int i = 0; i < DIGITS; i++) begin
        seg_q[i] <= (i < 3) ? SegZero : 7'h00;
        dp_q[i]  <= (i == 2);
      end
    end else begin
      wp_q <= wp_d;
      for (int i = 0; i < DIGITS; i++) begin
        if (wr_i.put && wr_i.start) begin
          seg_q[i] <= 7'h00;
          dp_q[i]  <= 1'b0;
        end
        if (wr_seg && wp_eff == CNT_W'(i)) begin
          seg_q[i] <= glyph[6:0];
          dp_q[i]  <= glyph[7];
        end
        if (wr_dp && dp_idx == CNT_W'(i)) begin
          dp_q[i] <= 1'b1;
        end
      end
    end
  end

  assign rd_seg_o   = ({1'b0, rd_idx_i} < Depth) ? {dp_q[rd_idx_i], seg_q[rd_idx_i]} : 8'h00;
  assign text_len_o = wp_q;

endmodule

[hw/rtl/ssd_serializer.sv]
module ssd_serializer #(
  parameter int FRAME_W = 20,
  parameter int BIT_W   = $clog2(FRAME_W + 1)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  logic [FRAME_W-1:0] frame_i,
  output logic               can_load_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               serial_bit_o,
  output logic               frame_last_o
);

  logic [FRAME_W-1:0] frame_q;
  logic [BIT_W-1:0]   left_q;
  logic               pop;

  assign pop        = out_valid_o && out_ready_i;
  assign can_load_o = (left_q == '0) || (left_q == BIT_W'(1) && out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q <= '0;
    end else if (load_i) begin
      left_q <= BIT_W'(FRAME_W);
    end else if (pop) begin
      left_q <= left_q - BIT_W'(1);
    end
  end

  // lsb goes out first
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      frame_q <= frame_i;
    end else if (pop) begin
      frame_q <= frame_q >> 1;
    end
  end

  assign out_valid_o  = left_q != '0;
  assign serial_bit_o = frame_q[0];
  assign frame_last_o = left_q == BIT_W'(1);

endmodule

[hw/rtl/seven_segment_scan_driver.sv]
// a frame word passes the input register, then the serializer frame register
// throughput: one input word per cycle while no frame is waiting; a frame is
//   DIGITS + 8 bit words, one per output handshake, and the next frame word
//   waits in the input register until the last bit of the current one leaves
// reset: first three digits hold 0, 0 and 0 with its point, start-up countdown 500
module seven_segment_scan_driver #(
  parameter int DIGITS = 12
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  kind_i,
  input  logic [7:0]  char_code_i,
  input  logic        string_start_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        serial_bit_o,
  output logic        frame_last_o,
  input  logic        startup_delay_we_i,
  input  logic [15:0] startup_delay_i
);
  import ssd_pkg::*;

  localparam int FrameW = DIGITS + 8;
  localparam int CntW   = $clog2(DIGITS + 1);
  localparam int IdxW   = (DIGITS > 1) ? $clog2(DIGITS) : 1;

  // input register
  logic       in_vld_q;
  kind_e      kind_q;
  logic [7:0] code_q;
  logic       start_q;

  // scan state
  logic [15:0]     cd_q, cd_d;      // 0 off, 1 scanning, above 1 counting down
  logic [CntW-1:0] scan_q, scan_d;

  logic              adv;           // input register word retires this cycle
  logic              emits;         // word produces a frame
  logic              scanning;
  logic              ser_can_load;
  logic              ser_load;
  logic [FrameW-1:0] frame;
  logic [DIGITS-1:0] sel_mask;
  logic [CntW-1:0]   sel_bit;
  logic [CntW-1:0]   text_len;
  logic [7:0]        rd_seg;
  ssd_wr_t           wr;

  // a word that makes no frame always retires; a frame word needs the serializer
  assign scanning   = (cd_q == 16'd1) && (scan_q < CntW'(DIGITS));
  assign emits      = (kind_q == KIND_OFF) || (kind_q == KIND_TICK && scanning);
  assign adv        = in_vld_q && (!emits || ser_can_load);
  assign in_ready_o = !in_vld_q || adv;
  assign ser_load   = adv && emits;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      kind_q  <= kind_e'(kind_i);
      code_q  <= char_code_i;
      start_q <= string_start_i;
    end
  end

  // text path into the segment store
  always_comb begin
    wr.put   = adv && (kind_q == KIND_CHAR);
    wr.start = start_q;
    wr.code  = code_q;
  end

  ssd_text_store #(
    .DIGITS (DIGITS)
  ) u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_i       (wr),
    .rd_idx_i   (scan_q[IdxW-1:0]),
    .rd_seg_o   (rd_seg),
    .text_len_o (text_len)
  );

  // countdown and scan position
  always_comb begin
    cd_d   = cd_q;
    scan_d = scan_q;
    if (adv) begin
      case (kind_q)
        KIND_ON:  cd_d = 16'd1;
        KIND_OFF: cd_d = 16'd0;
        KIND_TICK: begin
          if (cd_q > 16'd1) begin
            cd_d = cd_q - 16'd1;
          end else if (cd_q == 16'd1) begin
            scan_d = scanning ? scan_q + CntW'(1) : '0;
          end
        end
        default: ;
      endcase
    end
    // a register write reloads the countdown
    if (startup_delay_we_i) begin
      cd_d = startup_delay_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cd_q   <= ResetDelay;
      scan_q <= '0;
    end else begin
      cd_q   <= cd_d;
      scan_q <= scan_d;
    end
  end

  // active-low digit select, text positions run right to left
  always_comb begin
    sel_bit = (scan_q < text_len) ? text_len - scan_q - CntW'(1) : scan_q;
    for (int i = 0; i < DIGITS; i++) begin
      sel_mask[i] = sel_bit != CntW'(i);
    end
    // display off sends an all-zero frame
    frame = (kind_q == KIND_OFF) ? '0 : {rd_seg, sel_mask};
  end

  ssd_serializer #(
    .FRAME_W (FrameW)
  ) u_ser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (ser_load),
    .frame_i      (frame),
    .can_load_o   (ser_can_load),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .serial_bit_o (serial_bit_o),
    .frame_last_o (frame_last_o)
  );

`ifndef SYNTHESIS
  a_load_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ser_load |-> ser_can_load)
    else $error("frame loaded over a frame in flight");

  a_stall_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && emits && !ser_can_load) |=> (in_vld_q && $stable(kind_q)))
    else $error("stalled frame word lost");

  a_off_stops : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && kind_q == KIND_OFF && !startup_delay_we_i) |=> (cd_q == 16'd0))
    else $error("display off did not stop scanning");
`endif

endmodule

[verif/tb.sv]
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ssd_pkg::*;

  localparam int DIGITS        = 12;
  localparam int PHASE_WORDS   = 28;   // words per register setting that change state
  localparam int IDLE_LIMIT    = 4000; // cycles with no handshake before giving up
  localparam int SETTLE_CYCLES = 8;    // a word with no frame may still sit in the input stage
  localparam int TAIL_CYCLES   = 20;   // leave room for any stray bit word at the end
  localparam int REPORT_LIMIT  = 10;

  localparam logic [7:0] FIRST_GLYPH = 8'h20;
  localparam logic [7:0] LAST_GLYPH  = 8'h7A;
  localparam logic [7:0] DOT_CHAR    = 8'h2E;
  localparam logic [7:0] DP_MASK     = 8'h80;

  // segment patterns for codes 0x20 .. 0x7a, bit 7 is the decimal point
  localparam logic [7:0] GLYPH_ROM [91] = '{
    8'h00, 8'h86, 8'h22, 8'h00, 8'h00, 8'h00, 8'h00, 8'h02,
    8'h39, 8'h0F, 8'h00, 8'h00, 8'h80, 8'h40, 8'h80, 8'h52,
    8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07,
    8'h7F, 8'h6F, 8'h09, 8'h48, 8'h00, 8'h48, 8'h00, 8'h08,
    8'h00, 8'h77, 8'h7C, 8'h39, 8'h5E, 8'h79, 8'h71, 8'h3D,
    8'h76, 8'h30, 8'h1E, 8'h72, 8'h38, 8'h37, 8'h54, 8'h5C,
    8'h73, 8'h67, 8'h50, 8'h6D, 8'h78, 8'h1C, 8'h3E, 8'h6A,
    8'h49, 8'h6E, 8'h5B, 8'h39, 8'h64, 8'h0F, 8'h23, 8'h08,
    8'h00,
    8'h77, 8'h7C, 8'h39, 8'h5E, 8'h79, 8'h71, 8'h3D, 8'h76,
    8'h30, 8'h1E, 8'h72, 8'h38, 8'h37, 8'h54, 8'h5C, 8'h73,
    8'h67, 8'h50, 8'h6D, 8'h78, 8'h1C, 8'h3E, 8'h6A, 8'h49,
    8'h6E, 8'h5B
  };

  // one shifted bit as it should leave the block
  typedef struct packed {
    logic serial;
    logic latch;
  } bit_word_t;

  // one row of the opening script; typed rows carry their frame by hand
  typedef struct packed {
    kind_e             kind;
    logic [7:0]        code;
    logic              start;
    logic              typed;
    logic              has_frame;
    logic [DIGITS-1:0] sel;
    logic [7:0]        seg;
  } script_row_t;

  localparam int SCRIPT_LEN = 25;
  localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
    // countdown still at its reset value: a tick only counts down
    '{KIND_TICK, 8'h00, 1'b0, 1'b1, 1'b0, 12'h000, 8'h00},
    // display off: all-zero frame
    '{KIND_OFF,  8'hFF, 1'b1, 1'b1, 1'b1, 12'h000, 8'h00},
    // tick while off does nothing
    '{KIND_TICK, 8'h00, 1'b0, 1'b1, 1'b0, 12'h000, 8'h00},
    '{KIND_ON,   8'h00, 1'b0, 1'b1, 1'b0, 12'h000, 8'h00},
    // reset text "000." with no string loaded: select follows the scan position
    '{KIND_TICK, 8'h00, 1'b0, 1'b1, 1'b1, 12'hFFE, 8'h3F},
    '{KIND_TICK, 8'h00, 1'b0, 1'b1, 1'b1, 12'hFFD, 8'h3F},
    '{KIND_TICK, 8'h00, 1'b0, 1'b1, 1'b1, 12'hFFB, 8'hBF},
    // new string opening with a dot: the dot is dropped
    '{KIND_CHAR, DOT_CHAR, 1'b1, 1'b1, 1'b0, 12'h000, 8'h00},
    // codes below and above the font turn blank
    '{KIND_CHAR, 8'h00, 1'b0, 1'b1, 1'b0, 12'h000, 8'h00},
    '{KIND_CHAR, 8'hFF, 1'b0, 1'b1, 1'b0, 12'h000, 8'h00},
    // both ends of the font
    '{KIND_CHAR, 8'h7A, 1'b0, 1'b1, 1'b0, 12'h000, 8'h00},
    '{KIND_CHAR, 8'h20, 1'b0, 1'b1, 1'b0, 12'h000, 8'h00},
    // dot lands on the space before it
    '{KIND_CHAR, DOT_CHAR, 1'b0, 1'b1, 1'b0, 12'h000, 8'h00},
    '{KIND_CHAR, 8'h37, 1'b0, 1'b1, 1'b0, 12'h000, 8'h00},
    '{KIND_CHAR, 8'h41, 1'b0, 1'b1, 1'b0, 12'h000, 8'h00},
    '{KIND_CHAR, 8'h62, 1'b0, 1'b1, 1'b0, 12'h000, 8'h00},
    '{KIND_CHAR, 8'h39, 1'b0, 1'b1, 1'b0, 12'h000, 8'h00},
    '{KIND_CHAR, 8'h2D, 1'b0, 1'b1, 1'b0, 12'h000, 8'h00},
    '{KIND_CHAR, 8'h48, 1'b0, 1'b1, 1'b0, 12'h000, 8'h00},
    '{KIND_CHAR, 8'h45, 1'b0, 1'b1, 1'b0, 12'h000, 8'h00},
    '{KIND_CHAR, 8'h4C, 1'b0, 1'b1, 1'b0, 12'h000, 8'h00},
    // buffer full: character and dot both dropped
    '{KIND_CHAR, 8'h58, 1'b0, 1'b1, 1'b0, 12'h000, 8'h00},
    '{KIND_CHAR, DOT_CHAR, 1'b0, 1'b1, 1'b0, 12'h000, 8'h00},
    // scan the loaded text, position 3, reversed select
    '{KIND_TICK, 8'h00, 1'b0, 1'b0, 1'b0, 12'h000, 8'h00},
    '{KIND_OFF,  8'h00, 1'b0, 1'b1, 1'b1, 12'h000, 8'h00}
  };

  logic        clk_i;
  logic        rst_ni              = 1'b0;
  logic        in_valid_i          = 1'b0;
  logic        in_ready_o;
  logic [1:0]  kind_i              = KIND_TICK;
  logic [7:0]  char_code_i         = 8'h00;
  logic        string_start_i      = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i         = 1'b0;
  logic        serial_bit_o;
  logic        frame_last_o;
  logic        startup_delay_we_i  = 1'b0;
  logic [15:0] startup_delay_i     = 16'd0;

  // mirror of the display state
  logic [7:0]  seg_store [DIGITS];
  logic [3:0]  scan_pos;
  logic [3:0]  text_len;
  logic [3:0]  wr_ptr;
  logic [15:0] countdown;

  bit_word_t   scan_bits_q [$];

  int mismatches      = 0;
  int words_sent      = 0;
  int frames_expected = 0;
  int settings_used   = 0;
  int idle_cycles     = 0;
  int stall_left      = 0;
  bit rx_steady       = 1'b0;
  bit tx_burst        = 1'b0;

  seven_segment_scan_driver #(
    .DIGITS(DIGITS)
  ) DUT (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .kind_i            (kind_i),
    .char_code_i       (char_code_i),
    .string_start_i    (string_start_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .serial_bit_o      (serial_bit_o),
    .frame_last_o      (frame_last_o),
    .startup_delay_we_i(startup_delay_we_i),
    .startup_delay_i   (startup_delay_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic logic [7:0] glyph_of(input logic [7:0] code);
    if (code < FIRST_GLYPH || code > LAST_GLYPH) begin
      return 8'h00;
    end
    return GLYPH_ROM[code - FIRST_GLYPH];
  endfunction

  function automatic void reset_display();
    foreach (seg_store[i]) seg_store[i] = 8'h00;
    seg_store[0] = 8'h3F;
    seg_store[1] = 8'h3F;
    seg_store[2] = 8'hBF;
    scan_pos  = '0;
    text_len  = '0;
    wr_ptr    = '0;
    countdown = 16'd500;
  endfunction

  // advance the mirror by one word; reports the frame it should shift out
  function automatic void apply_word(input kind_e k, input logic [7:0] code,
                                     input logic start, output logic makes_frame,
                                     output logic [DIGITS-1:0] sel,
                                     output logic [7:0] seg, output logic took_effect);
    int bit_pos;
    makes_frame = 1'b0;
    sel         = '0;
    seg         = '0;
    took_effect = 1'b1;
    case (k)
      KIND_CHAR: begin
        if (start) begin
          foreach (seg_store[i]) seg_store[i] = 8'h00;
          text_len = '0;
          wr_ptr   = '0;
        end
        if (wr_ptr < DIGITS) begin
          if (code == DOT_CHAR) begin
            // a dot with nothing before it is dropped
            if (wr_ptr > 0) seg_store[wr_ptr - 1] = seg_store[wr_ptr - 1] | DP_MASK;
          end else begin
            seg_store[wr_ptr] = glyph_of(code);
            wr_ptr   = wr_ptr + 4'd1;
            text_len = text_len + 4'd1;
          end
        end else begin
          took_effect = 1'b0;
        end
      end
      KIND_ON: begin
        countdown = 16'd1;
      end
      KIND_OFF: begin
        countdown   = 16'd0;
        makes_frame = 1'b1;
      end
      default: begin
        if (countdown > 16'd1) begin
          countdown = countdown - 16'd1;
        end else if (countdown == 16'd0) begin
          took_effect = 1'b0;
        end else if (scan_pos < DIGITS) begin
          // text digits are selected right to left, the rest by position
          if (scan_pos < text_len) bit_pos = int'(text_len) - int'(scan_pos) - 1;
          else bit_pos = int'(scan_pos);
          sel          = '1;
          sel[bit_pos] = 1'b0;
          seg          = seg_store[scan_pos];
          makes_frame  = 1'b1;
          scan_pos     = scan_pos + 4'd1;
        end else begin
          scan_pos = '0;
        end
      end
    endcase
  endfunction

  // select bits first, then segments, lsb first; latch on the last one
  function automatic void queue_frame(input logic [DIGITS-1:0] sel, input logic [7:0] seg);
    bit_word_t w;
    for (int i = 0; i < DIGITS; i++) begin
      w.serial = sel[i];
      w.latch  = 1'b0;
      scan_bits_q.push_back(w);
    end
    for (int i = 0; i < 8; i++) begin
      w.serial = seg[i];
      w.latch  = (i == 7);
      scan_bits_q.push_back(w);
    end
    frames_expected++;
  endfunction

  // most gaps short, a few long, none while bursting
  function automatic int sender_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (tx_burst || roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // valid goes up at an edge and stays up until the word is taken
  task automatic send_word(input kind_e k, input logic [7:0] code, input logic start,
                           output logic makes_frame, output logic [DIGITS-1:0] sel,
                           output logic [7:0] seg, output logic took_effect);
    in_valid_i     <= 1'b1;
    kind_i         <= k;
    char_code_i    <= code;
    string_start_i <= start;
    do @(posedge clk_i); while (!in_ready_o);
    apply_word(k, code, start, makes_frame, sel, seg, took_effect);
    words_sent++;
  endtask

  task automatic pause_sender(input int gap);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // drop valid and hold off until every expected bit word has left
  task automatic go_quiet();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (scan_bits_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_delay(input logic [15:0] value);
    go_quiet();
    // a word that shifts nothing may still be in the input stage
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    startup_delay_we_i <= 1'b1;
    startup_delay_i    <= value;
    @(posedge clk_i);
    startup_delay_we_i <= 1'b0;
    countdown = value;
    settings_used++;
  endtask

  task automatic send_and_queue(input kind_e k, input logic [7:0] code, input logic start,
                                output logic took_effect);
    logic              makes_frame;
    logic [DIGITS-1:0] sel;
    logic [7:0]        seg;
    send_word(k, code, start, makes_frame, sel, seg, took_effect);
    if (makes_frame) queue_frame(sel, seg);
  endtask

  function automatic logic [7:0] random_text_code();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return 8'($urandom_range(FIRST_GLYPH, LAST_GLYPH));
    if (roll < 85) return DOT_CHAR;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic void note_mismatch(input string what, input bit_word_t want,
                                        input bit_word_t got);
    mismatches++;
    if (mismatches <= REPORT_LIMIT) begin
      $display("%0t: %s: expected serial=%0b latch=%0b, got serial=%0b latch=%0b",
               $realtime, what, want.serial, want.latch, got.serial, got.latch);
    end
  endfunction

  // output side: random stalls, most of them short, with steady stretches
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left  <= stall_left - 1;
      out_ready_i <= 1'b0;
    end else if (!rx_steady && $urandom_range(0, 99) < 25) begin
      stall_left  <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                 : $urandom_range(0, 3);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // each bit word against the oldest expectation
  always @(posedge clk_i) begin
    bit_word_t got;
    bit_word_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got.serial = serial_bit_o;
      got.latch  = frame_last_o;
      if (scan_bits_q.size() == 0) begin
        want = '0;
        note_mismatch("bit word with nothing expected", want, got);
      end else begin
        want = scan_bits_q.pop_front();
        if (got.serial !== want.serial) note_mismatch("serial bit", want, got);
        else if (got.latch !== want.latch) note_mismatch("frame last flag", want, got);
      end
    end
  end

  // watchdog on handshakes of either channel
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || !rst_ni) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no handshake for %0d cycles, %0d bit words outstanding",
                 $realtime, IDLE_LIMIT, scan_bits_q.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin
    logic [15:0]       plan [8];
    logic              makes_frame;
    logic [DIGITS-1:0] sel;
    logic [7:0]        seg;
    logic              took_effect;
    int                counted;
    int                roll;
    int                str_len;
    kind_e             k;
    logic [7:0]        code;
    logic              start;

    reset_display();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // opening script at the reset setting
    for (int r = 0; r < SCRIPT_LEN; r++) begin
      send_word(SCRIPT[r].kind, SCRIPT[r].code, SCRIPT[r].start,
                makes_frame, sel, seg, took_effect);
      if (SCRIPT[r].typed) begin
        if (SCRIPT[r].has_frame) queue_frame(SCRIPT[r].sel, SCRIPT[r].seg);
      end else if (makes_frame) begin
        queue_frame(sel, seg);
      end
      pause_sender(sender_gap());
    end

    // settings: short countdown, off, both extremes, straight to scan, random ones
    plan[0] = 16'd3;
    plan[1] = 16'd0;
    plan[2] = 16'hFFFF;
    plan[3] = 16'd1;
    plan[4] = 16'($urandom_range(0, 65535));
    plan[5] = 16'd2;
    plan[6] = 16'd500;
    plan[7] = 16'($urandom_range(0, 40));

    for (int p = 0; p < 8; p++) begin
      write_delay(plan[p]);
      rx_steady = (p == 3);
      tx_burst  = (p == 5);
      counted   = 0;

      // even settings open with a whole string and display on
      if (p % 2 == 0) begin
        str_len = $urandom_range(1, 14);
        for (int c = 0; c < str_len; c++) begin
          send_and_queue(KIND_CHAR, random_text_code(), (c == 0), took_effect);
          if (took_effect) counted++;
          pause_sender(sender_gap());
        end
        send_and_queue(KIND_ON, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                       took_effect);
        counted++;
        pause_sender(sender_gap());
      end

      while (counted < PHASE_WORDS) begin
        roll  = $urandom_range(0, 99);
        k     = kind_e'($urandom_range(0, 3));
        code  = 8'($urandom_range(0, 255));
        start = 1'($urandom_range(0, 1));
        if (roll < 50) begin
          k = KIND_TICK;
        end else if (roll < 80) begin
          k     = KIND_CHAR;
          code  = random_text_code();
          start = ($urandom_range(0, 99) < 12);
        end else if (roll < 88) begin
          k = KIND_ON;
        end else if (roll < 94) begin
          k = KIND_OFF;
        end
        // otherwise every field is noise
        send_and_queue(k, code, start, took_effect);
        if (took_effect) counted++;
        // odd settings hold the sender halfway until the output side drains
        if (p % 2 == 1 && counted == PHASE_WORDS / 2 && took_effect) go_quiet();
        else pause_sender(sender_gap());
      end
    end

    go_quiet();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("sent %0d input words over %0d delay settings plus reset, %0d frames expected",
             words_sent, settings_used, frames_expected);
    $display("%0d mismatches, %0d bit words left over", mismatches, scan_bits_q.size());
    if (mismatches == 0 && scan_bits_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
